[rtl/system_control_space_regs_macros.svh]
// Assertion macros for the system control space registers
`ifndef SYSTEM_CONTROL_SPACE_REGS_MACROS_SVH
`define SYSTEM_CONTROL_SPACE_REGS_MACROS_SVH
// implication checked on every edge outside reset
`define SCS_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("scs check failed");
// implication checked in the next cycle
`define SCS_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("scs check failed");
`endif

[rtl/scs_pkg.sv]
// Package with types and constants for the system control space registers
package scs_pkg;
    localparam int unsigned NumIrqsDefault  = 26;
    localparam int unsigned NumCoresDefault = 2;
    localparam logic [31:0] CpuIdReset      = 32'h410C_C601;
    localparam logic [31:0] AircrKey        = 32'h05FA_0000;
    localparam logic [31:0] CcrValue        = 32'h0000_0208;
    localparam logic [4:0]  ScrMask         = 5'h16;

    localparam logic [1:0] OpRead  = 2'd0;
    localparam logic [1:0] OpWrite = 2'd1;
    localparam logic [1:0] OpTick  = 2'd2;

    localparam logic [11:0] OffCsr   = 12'h010;
    localparam logic [11:0] OffRvr   = 12'h014;
    localparam logic [11:0] OffCvr   = 12'h018;
    localparam logic [11:0] OffIser  = 12'h100;
    localparam logic [11:0] OffIcer  = 12'h180;
    localparam logic [11:0] OffIspr  = 12'h200;
    localparam logic [11:0] OffIcpr  = 12'h280;
    localparam logic [11:0] OffCpuid = 12'hD00;
    localparam logic [11:0] OffIcsr  = 12'hD04;
    localparam logic [11:0] OffVtor  = 12'hD08;
    localparam logic [11:0] OffAircr = 12'hD0C;
    localparam logic [11:0] OffScr   = 12'hD10;
    localparam logic [11:0] OffCcr   = 12'hD14;
    localparam logic [11:0] OffShpr2 = 12'hD1C;
    localparam logic [11:0] OffShpr3 = 12'hD20;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        core_sel;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic [15:0] tick_count;
        logic [5:0]  active_exception;
    } scs_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        reset_request;
        logic        sleep_on_exit;
        logic        systick_pending;
        logic        pendsv_pending;
        logic [25:0] irq_pending_bits;
    } scs_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } scs_state_t;
endpackage

[rtl/system_control_space_regs.sv]
// Top level of the banked system control space registers
// Usage:
//   s_valid/s_ready/s_data carry one transfer per access: a register read, a
//   register write or a run of SysTick cycles for the core picked by core_sel.
//   m_valid/m_ready/m_data return exactly one result per accepted transfer.
//   cfg_we/cfg_wdata set the value read back from CPUID.
// Sequencing:
//   A read or write passes through ST_TICK and ST_DONE; the result is then registered.
//   A tick transfer with ENABLE set stays in ST_TICK until tick_count clock ticks are done: the single
//   shared counter step unit advances one clock tick per cycle.
//   The block takes one transfer at a time; s_ready is high only when no
//   transfer is in progress and the output register is free.
// Reset:
//   aresetn low clears the state machine, the result flag, SysTick, NVIC and SCB registers; CPUID gets CpuIdReset.
// Stall:
//   When m_ready is low the result is held in the output register and no new
//   transfer is accepted until it is taken.
module system_control_space_regs #(
    parameter int unsigned NUM_IRQS  = scs_pkg::NumIrqsDefault,
    parameter int unsigned NUM_CORES = scs_pkg::NumCoresDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  scs_pkg::scs_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output scs_pkg::scs_out_t m_data,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata
);
    localparam int unsigned CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [31:0] IrqMask = 32'((64'd1 << NUM_IRQS) - 64'd1);

    scs_pkg::scs_state_t state_reg, state_next;
    scs_pkg::scs_in_t    item_reg;
    logic [CW-1:0]       core_reg;
    logic [15:0]         cnt_reg;
    logic [31:0]         cpu_id_reg;
    logic                out_valid_reg;
    scs_pkg::scs_out_t   out_reg;

    logic [2:0]  tick_ctrl_reg    [NUM_CORES];
    logic        count_flag_reg   [NUM_CORES];
    logic [23:0] tick_reload_reg  [NUM_CORES];
    logic [23:0] tick_current_reg [NUM_CORES];
    logic [4:0]  sleep_ctrl_reg   [NUM_CORES];
    logic [31:0] irq_en_reg       [NUM_CORES];
    logic [31:0] irq_pend_reg     [NUM_CORES];
    logic [1:0]  sys_pend_reg     [NUM_CORES];
    logic [31:0] vtor_reg         [NUM_CORES];
    logic [31:0] irq_prio_reg     [NUM_CORES][8];
    logic [7:0]  sys_prio_reg     [NUM_CORES][3];

    logic [CW-1:0] core_in;
    logic [23:0]   step_value;
    logic          step_zero;
    logic          accept;
    logic          in_ipr;
    logic [2:0]    ipr_word;
    logic [31:0]   rd_value;
    logic          rst_req;
    logic [31:0]   wd;
    logic [11:0]   off;
    logic [CW-1:0] c;
    logic [31:0]   irq_pend_next;
    logic [1:0]    sys_pend_next;
    logic [4:0]    sleep_ctrl_next;

    always_comb begin
        if (NUM_CORES > 1) begin
            core_in = CW'(s_data.core_sel);
        end else begin
            core_in = '0;
        end
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == scs_pkg::ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign c        = core_reg;
    assign off      = item_reg.reg_offset;
    assign wd       = item_reg.write_data;
    assign in_ipr   = (off >= 12'h400) && (off < 12'h420);
    assign ipr_word = off[4:2];

    scs_tick_unit u_tick (
        .current    (tick_current_reg[c]),
        .reload     (tick_reload_reg[c]),
        .next_value (step_value),
        .hit_zero   (step_zero)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scs_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = scs_pkg::ST_TICK;
                end
            end
            scs_pkg::ST_TICK: begin
                if (item_reg.opcode != scs_pkg::OpTick || !tick_ctrl_reg[c][0]
                    || cnt_reg == 16'd0) begin
                    state_next = scs_pkg::ST_DONE;
                end
            end
            scs_pkg::ST_DONE: state_next = scs_pkg::ST_IDLE;
            default: state_next = scs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rd_value = '0;
        unique case (off)
            scs_pkg::OffCsr: rd_value = {15'd0, count_flag_reg[c], 13'd0, tick_ctrl_reg[c]};
            scs_pkg::OffRvr: rd_value = {8'd0, tick_reload_reg[c]};
            scs_pkg::OffCvr: rd_value = {8'd0, tick_current_reg[c]};
            scs_pkg::OffIser, scs_pkg::OffIcer: rd_value = irq_en_reg[c] & IrqMask;
            scs_pkg::OffIspr, scs_pkg::OffIcpr: rd_value = irq_pend_reg[c] & IrqMask;
            scs_pkg::OffCpuid: rd_value = cpu_id_reg;
            scs_pkg::OffIcsr: rd_value = {3'd0, sys_pend_reg[c][1], 1'b0,
                                          sys_pend_reg[c][0], 20'd0,
                                          item_reg.active_exception};
            scs_pkg::OffVtor: rd_value = vtor_reg[c];
            scs_pkg::OffAircr: rd_value = scs_pkg::AircrKey;
            scs_pkg::OffScr: rd_value = {27'd0, sleep_ctrl_reg[c]};
            scs_pkg::OffCcr: rd_value = scs_pkg::CcrValue;
            scs_pkg::OffShpr2: rd_value = {sys_prio_reg[c][0], 24'd0};
            scs_pkg::OffShpr3: rd_value = {sys_prio_reg[c][2], sys_prio_reg[c][1], 16'd0};
            default: begin
                if (in_ipr) begin
                    for (int b = 0; b < 4; b++) begin
                        if (32'({ipr_word, 2'(b)}) < NUM_IRQS) begin
                            rd_value[b*8 +: 8] = irq_prio_reg[c][ipr_word][b*8 +: 8];
                        end
                    end
                end
            end
        endcase
    end

    always_comb begin
        irq_pend_next   = irq_pend_reg[c];
        sys_pend_next   = sys_pend_reg[c];
        sleep_ctrl_next = sleep_ctrl_reg[c];
        if (item_reg.opcode == scs_pkg::OpWrite) begin
            unique case (off)
                scs_pkg::OffIspr: irq_pend_next = irq_pend_reg[c] | (wd & IrqMask);
                scs_pkg::OffIcpr: irq_pend_next = irq_pend_reg[c] & ~(wd & IrqMask);
                scs_pkg::OffIcsr: begin
                    sys_pend_next[1] = wd[27] ? 1'b0 : (wd[28] ? 1'b1 : sys_pend_reg[c][1]);
                    sys_pend_next[0] = wd[25] ? 1'b0 : (wd[26] ? 1'b1 : sys_pend_reg[c][0]);
                end
                scs_pkg::OffScr: sleep_ctrl_next = wd[4:0] & scs_pkg::ScrMask;
                default: begin
                end
            endcase
        end
    end

    assign rst_req = (off == scs_pkg::OffAircr) && (wd[31:16] == scs_pkg::AircrKey[31:16])
                     && wd[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= scs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cpu_id_reg    <= scs_pkg::CpuIdReset;
            for (int i = 0; i < NUM_CORES; i++) begin
                tick_ctrl_reg[i]    <= '0;
                count_flag_reg[i]   <= 1'b0;
                tick_reload_reg[i]  <= '0;
                tick_current_reg[i] <= '0;
                sleep_ctrl_reg[i]   <= '0;
                irq_en_reg[i]       <= '0;
                irq_pend_reg[i]     <= '0;
                sys_pend_reg[i]     <= '0;
                vtor_reg[i]         <= '0;
                for (int j = 0; j < 8; j++) irq_prio_reg[i][j] <= '0;
                for (int j = 0; j < 3; j++) sys_prio_reg[i][j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                cpu_id_reg <= cfg_wdata;
            end
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                item_reg <= s_data;
                core_reg <= core_in;
                cnt_reg  <= s_data.tick_count;
            end
            if (state_reg == scs_pkg::ST_TICK && item_reg.opcode == scs_pkg::OpTick
                && tick_ctrl_reg[c][0] && cnt_reg != 16'd0) begin
                tick_current_reg[c] <= step_value;
                cnt_reg <= cnt_reg - 16'd1;
                if (step_zero) begin
                    count_flag_reg[c] <= 1'b1;
                    if (tick_ctrl_reg[c][1]) begin
                        sys_pend_reg[c][0] <= 1'b1;
                    end
                end
            end
            if (state_reg == scs_pkg::ST_DONE) begin
                out_valid_reg          <= 1'b1;
                out_reg.read_data      <= (item_reg.opcode == scs_pkg::OpRead) ? rd_value : '0;
                out_reg.reset_request  <= (item_reg.opcode == scs_pkg::OpWrite) && rst_req;
                out_reg.sleep_on_exit  <= sleep_ctrl_next[1];
                out_reg.systick_pending <= sys_pend_next[0];
                out_reg.pendsv_pending <= sys_pend_next[1];
                out_reg.irq_pending_bits <= irq_pend_next[25:0] & IrqMask[25:0];
                irq_pend_reg[c]        <= irq_pend_next;
                sys_pend_reg[c]        <= sys_pend_next;
                sleep_ctrl_reg[c]      <= sleep_ctrl_next;
                if (item_reg.opcode == scs_pkg::OpWrite) begin
                    unique case (off)
                        scs_pkg::OffCsr: tick_ctrl_reg[c] <= wd[2:0];
                        scs_pkg::OffRvr: tick_reload_reg[c] <= wd[23:0];
                        scs_pkg::OffCvr: begin
                            tick_current_reg[c] <= '0;
                            count_flag_reg[c]   <= 1'b0;
                        end
                        scs_pkg::OffIser: irq_en_reg[c] <= irq_en_reg[c] | (wd & IrqMask);
                        scs_pkg::OffIcer: irq_en_reg[c] <= irq_en_reg[c] & ~(wd & IrqMask);
                        scs_pkg::OffVtor: vtor_reg[c] <= wd;
                        scs_pkg::OffShpr2: sys_prio_reg[c][0] <= wd[31:24];
                        scs_pkg::OffShpr3: begin
                            sys_prio_reg[c][2] <= wd[31:24];
                            sys_prio_reg[c][1] <= wd[23:16];
                        end
                        default: begin
                            if (in_ipr) begin
                                for (int b = 0; b < 4; b++) begin
                                    if (32'({ipr_word, 2'(b)}) < NUM_IRQS) begin
                                        irq_prio_reg[c][ipr_word][b*8 +: 8] <= wd[b*8 +: 8];
                                    end
                                end
                            end
                        end
                    endcase
                end else if (item_reg.opcode == scs_pkg::OpRead && off == scs_pkg::OffCsr) begin
                    count_flag_reg[c] <= 1'b0;
                end
            end
        end
    end

    `include "system_control_space_regs_macros.svh"

    `SCS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != scs_pkg::ST_IDLE, !s_ready)
    `SCS_ASSERT_NEXT(a_done_gives_result, aclk, aresetn, state_reg == scs_pkg::ST_DONE, m_valid)
    `SCS_ASSERT_IMPL(a_rst_only_write, aclk, aresetn, m_valid && m_data.reset_request,
                     m_data.read_data == 32'd0)
endmodule

[rtl/scs_tick_unit.sv]
// SysTick down-counter step shared by all cores
module scs_tick_unit (
    input  logic [23:0] current,
    input  logic [23:0] reload,
    output logic [23:0] next_value,
    output logic        hit_zero
);
    always_comb begin
        if (current == 24'd0) begin
            next_value = reload;
            hit_zero   = 1'b0;
        end else begin
            next_value = current - 24'd1;
            hit_zero   = (current == 24'd1);
        end
    end
endmodule
